// File: rtl/core/target_tracking_encoder_emulator_core_defines.svh
// Assertion macros for the light bar encoder emulator RTL.
`ifndef TARGET_TRACKING_ENCODER_EMULATOR_CORE_DEFINES_SVH
`define TARGET_TRACKING_ENCODER_EMULATOR_CORE_DEFINES_SVH

// Checked only outside reset.
`define TTE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define TTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/tte_pkg.sv
// Types, constants and quantizing functions of the light bar encoder emulator.
package tte_pkg;

    localparam int TTE_CAL_STEPS  = 10;
    localparam int TTE_TIMER_BITS = 16;

    localparam int STEP_INT_W   = 10;
    localparam int EDGE_INT_W   = 10;
    localparam int PRESS_TIME_W = 13;

    localparam logic [STEP_INT_W-1:0]   STEP_INT_RST   = 10'd50;
    localparam logic [EDGE_INT_W-1:0]   EDGE_INT_RST   = 10'd5;
    localparam logic [PRESS_TIME_W-1:0] PRESS_TIME_RST = 13'd300;

    localparam logic [1:0] REG_STEP_INT   = 2'd0;
    localparam logic [1:0] REG_EDGE_INT   = 2'd1;
    localparam logic [1:0] REG_PRESS_TIME = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [1:0] PH_POWER = 2'd0;
    localparam logic [1:0] PH_LEVEL = 2'd1;
    localparam logic [1:0] PH_TINT  = 2'd2;
    localparam logic [1:0] PH_IDLE  = 2'd3;

    localparam int LINE_BTN = 0;
    localparam int LINE_A   = 1;
    localparam int LINE_B   = 2;

    localparam int LevelMax  = 7;
    localparam int LevelDiv  = 255;
    localparam int TintMax   = 8;
    localparam int TempLo    = 152;
    localparam int TempHi    = 304;
    localparam int TempSpan  = 19;

    typedef struct packed {
        logic [PRESS_TIME_W-1:0] press_time;
        logic [EDGE_INT_W-1:0]   edge_int;
        logic [STEP_INT_W-1:0]   step_int;
    } t_cfg;

    typedef struct packed {
        logic       power;
        logic [2:0] level;
        logic [3:0] tint;
    } t_target;

    typedef struct packed {
        logic calibrating;
        logic phase_b;
        logic phase_a;
        logic button;
    } t_pins;

    function automatic logic [2:0] level_index(input logic [7:0] b);
        logic [10:0] x;
        logic [2:0]  q;
        x = 11'(b) * 11'(LevelMax) + 11'd127;
        q = '0;
        for (int k = 1; k <= LevelMax; k++) begin
            if (x >= 11'(LevelDiv * k)) begin
                q = q + 3'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [3:0] tint_index(input logic [8:0] m);
        logic [8:0] mc;
        logic [7:0] d;
        logic [3:0] q;
        mc = m;
        if (mc < 9'(TempLo)) begin
            mc = 9'(TempLo);
        end
        if (mc > 9'(TempHi)) begin
            mc = 9'(TempHi);
        end
        d = 8'(mc - 9'(TempLo) + 9'(TempSpan / 2));
        q = '0;
        for (int k = 1; k <= TintMax; k++) begin
            if (d >= 8'(TempSpan * k)) begin
                q = q + 4'd1;
            end
        end
        return 4'(TintMax) - q;
    endfunction

endpackage

// File: rtl/core/target_tracking_encoder_emulator_core.sv
// Each accepted input beat is held in the input register, then moved to the result
// register when that is empty or being read. Throughput: one beat per cycle while
// m_axis_tready stays high; a stalled output holds back new input beats.
// Reset: synchronous, active low; the configuration and control registers return to
// their defaults, the internal pin lines go high and the start-up calibration is armed.
// Top level of the light bar encoder emulator.
module target_tracking_encoder_emulator_core
    import tte_pkg::*;
#(
    parameter int CAL_STEPS  = TTE_CAL_STEPS,
    parameter int TIMER_BITS = TTE_TIMER_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // power_on [0], brightness_level [8:1], temp_mireds [17:9], zero fill
    input  logic [23:0] s_axis_tdata,
    // command [0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // button_line [0], phase_a_line [1], phase_b_line [2], calibrating [3], zero fill
    output logic [7:0]  m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [17:0] r_in_data;
    logic        r_out_valid;
    t_pins       r_out_pins;
    logic        adv;
    t_target     target;
    t_pins       pins_next;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_int   <= STEP_INT_RST;
            r_cfg.edge_int   <= EDGE_INT_RST;
            r_cfg.press_time <= PRESS_TIME_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_STEP_INT:   r_cfg.step_int   <= pwdata[STEP_INT_W-1:0];
                REG_EDGE_INT:   r_cfg.edge_int   <= pwdata[EDGE_INT_W-1:0];
                REG_PRESS_TIME: r_cfg.press_time <= pwdata[PRESS_TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STEP_INT:   prdata = 32'(r_cfg.step_int);
            REG_EDGE_INT:   prdata = 32'(r_cfg.edge_int);
            REG_PRESS_TIME: prdata = 32'(r_cfg.press_time);
            default:        prdata = '0;
        endcase
    end

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_data <= s_axis_tdata[17:0];
        end
        if (adv) begin
            r_out_pins <= pins_next;
        end
    end

    assign target.power = r_in_data[0];
    assign target.level = level_index(r_in_data[8:1]);
    assign target.tint  = tint_index(r_in_data[17:9]);

    tte_ctrl #(
        .CAL_STEPS  (CAL_STEPS),
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_load      (r_in_cmd),
        .i_target    (target),
        .i_cfg       (r_cfg),
        .o_pins_next (pins_next)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_pins};

endmodule

// File: rtl/core/tte_ctrl.sv
// Calibration and adjustment sequencer with the quadrature edge generator.
`include "target_tracking_encoder_emulator_core_defines.svh"

module tte_ctrl
    import tte_pkg::*;
#(
    parameter int CAL_STEPS  = TTE_CAL_STEPS,
    parameter int TIMER_BITS = TTE_TIMER_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_load,
    input  t_target i_target,
    input  t_cfg    i_cfg,
    output t_pins   o_pins_next
);

    localparam int CW    = $clog2(2 * CAL_STEPS + 1);
    localparam int CMP_W = (TIMER_BITS > PRESS_TIME_W) ? TIMER_BITS : PRESS_TIME_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic                  r_cal_active, n_cal_active;
    logic [CW-1:0]         r_cal_count, n_cal_count;
    logic [1:0]            r_phase, n_phase;
    logic                  r_held, n_held;
    logic                  r_pwr_now, n_pwr_now;
    logic [2:0]            r_lvl_now, n_lvl_now;
    logic [3:0]            r_tint_now, n_tint_now;
    t_target               r_goal, n_goal;
    logic [2:0]            r_edge_step, n_edge_step;
    logic [1:0]            r_edge_dir, n_edge_dir;
    logic [2:0]            r_lines, n_lines;
    logic [TIMER_BITS-1:0] r_since_step, n_since_step;
    logic [TIMER_BITS-1:0] r_since_press, n_since_press;
    logic [TIMER_BITS-1:0] r_since_edge, n_since_edge;

    always_comb begin
        logic press_done;
        int   lead;
        int   lag;
        n_cal_active  = r_cal_active;
        n_cal_count   = r_cal_count;
        n_phase       = r_phase;
        n_held        = r_held;
        n_pwr_now     = r_pwr_now;
        n_lvl_now     = r_lvl_now;
        n_tint_now    = r_tint_now;
        n_goal        = r_goal;
        n_edge_step   = r_edge_step;
        n_edge_dir    = r_edge_dir;
        n_lines       = r_lines;
        n_since_step  = r_since_step;
        n_since_press = r_since_press;
        n_since_edge  = r_since_edge;
        press_done    = 1'b0;
        lead          = LINE_B;
        lag           = LINE_A;
        if (i_en && i_load) begin
            n_goal = i_target;
        end else if (i_en) begin
            n_since_step  = (r_since_step == TMAX) ? TMAX : r_since_step + 1'b1;
            n_since_press = (r_since_press == TMAX) ? TMAX : r_since_press + 1'b1;
            n_since_edge  = (r_since_edge == TMAX) ? TMAX : r_since_edge + 1'b1;
            press_done = CMP_W'(n_since_press) > CMP_W'(i_cfg.press_time);
            if (CMP_W'(n_since_step) >= CMP_W'(i_cfg.step_int)) begin
                if (r_cal_active) begin
                    if (r_cal_count < CW'(CAL_STEPS)) begin
                        n_edge_step = 3'd1;
                        n_edge_dir  = DIR_DOWN;
                        n_cal_count = r_cal_count + 1'b1;
                    end else if (r_cal_count < CW'(2 * CAL_STEPS)) begin
                        if (!r_held) begin
                            n_held = 1'b1;
                            n_lines[LINE_BTN] = 1'b0;
                            n_since_press = '0;
                        end else if (press_done) begin
                            n_edge_step = 3'd1;
                            n_edge_dir  = DIR_DOWN;
                            n_cal_count = r_cal_count + 1'b1;
                        end
                    end else if (r_held) begin
                        if (press_done) begin
                            n_held = 1'b0;
                            n_lines[LINE_BTN] = 1'b1;
                            n_since_press = '0;
                        end
                    end else if (press_done) begin
                        n_cal_active = 1'b0;
                    end
                end else begin
                    case (r_phase)
                        PH_POWER: begin
                            if (r_pwr_now == r_goal.power) begin
                                n_phase = PH_LEVEL;
                            end else if (!r_held) begin
                                n_held = 1'b1;
                                n_lines[LINE_BTN] = 1'b0;
                                n_since_press = '0;
                            end else if (press_done) begin
                                n_held = 1'b0;
                                n_lines[LINE_BTN] = 1'b1;
                                n_pwr_now = r_goal.power;
                            end
                        end
                        PH_LEVEL: begin
                            if (!r_pwr_now || r_lvl_now == r_goal.level) begin
                                n_phase = PH_TINT;
                            end else if (r_lvl_now > r_goal.level) begin
                                n_edge_step = 3'd1;
                                n_edge_dir  = DIR_DOWN;
                                n_lvl_now   = r_lvl_now - 1'b1;
                            end else begin
                                n_edge_step = 3'd1;
                                n_edge_dir  = DIR_UP;
                                n_lvl_now   = r_lvl_now + 1'b1;
                            end
                        end
                        PH_TINT: begin
                            if (!r_pwr_now) begin
                                n_phase = PH_IDLE;
                            end else if (r_tint_now == r_goal.tint) begin
                                if (!r_held) begin
                                    if (press_done) begin
                                        n_phase = PH_IDLE;
                                    end
                                end else begin
                                    n_held = 1'b0;
                                    n_lines[LINE_BTN] = 1'b1;
                                    n_since_press = '0;
                                end
                            end else if (!r_held) begin
                                n_held = 1'b1;
                                n_lines[LINE_BTN] = 1'b0;
                                n_since_press = '0;
                            end else if (press_done) begin
                                n_edge_step = 3'd1;
                                if (r_tint_now > r_goal.tint) begin
                                    n_edge_dir = DIR_DOWN;
                                    n_tint_now = r_tint_now - 1'b1;
                                end else begin
                                    n_edge_dir = DIR_UP;
                                    n_tint_now = r_tint_now + 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_POWER;
                        end
                    endcase
                end
                n_since_step = '0;
            end
            if (CMP_W'(n_since_edge) >= CMP_W'(i_cfg.edge_int) &&
                n_edge_dir != DIR_NONE && n_edge_step != 3'd0) begin
                if (n_edge_dir == DIR_UP) begin
                    lead = LINE_A;
                    lag  = LINE_B;
                end
                case (n_edge_step)
                    3'd1:    n_lines[lead] = 1'b0;
                    3'd2:    n_lines[lag]  = 1'b0;
                    3'd3:    n_lines[lead] = 1'b1;
                    3'd4:    n_lines[lag]  = 1'b1;
                    default: ;
                endcase
                if (n_edge_step >= 3'd4) begin
                    n_edge_step = 3'd0;
                    n_edge_dir  = DIR_NONE;
                end else begin
                    n_edge_step = n_edge_step + 3'd1;
                end
                n_since_edge = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_active  <= 1'b1;
            r_cal_count   <= '0;
            r_phase       <= PH_POWER;
            r_held        <= 1'b0;
            r_pwr_now     <= 1'b0;
            r_lvl_now     <= '0;
            r_tint_now    <= '0;
            r_goal        <= '0;
            r_edge_step   <= '0;
            r_edge_dir    <= DIR_NONE;
            r_lines       <= '1;
            r_since_step  <= '0;
            r_since_press <= '0;
            r_since_edge  <= '0;
        end else begin
            r_cal_active  <= n_cal_active;
            r_cal_count   <= n_cal_count;
            r_phase       <= n_phase;
            r_held        <= n_held;
            r_pwr_now     <= n_pwr_now;
            r_lvl_now     <= n_lvl_now;
            r_tint_now    <= n_tint_now;
            r_goal        <= n_goal;
            r_edge_step   <= n_edge_step;
            r_edge_dir    <= n_edge_dir;
            r_lines       <= n_lines;
            r_since_step  <= n_since_step;
            r_since_press <= n_since_press;
            r_since_edge  <= n_since_edge;
        end
    end

    assign o_pins_next.button      = n_lines[LINE_BTN];
    assign o_pins_next.phase_a     = n_lines[LINE_A];
    assign o_pins_next.phase_b     = n_lines[LINE_B];
    assign o_pins_next.calibrating = n_cal_active;

    // Calibration never restarts once it has finished.
    `TTE_ASSERT(a_cal_once, i_clk, i_rst_n, !r_cal_active |=> !r_cal_active, "calibration restarted")
    // A pending encoder step always carries a direction.
    `TTE_ASSERT(a_step_dir, i_clk, i_rst_n, (r_edge_step != 3'd0) == (r_edge_dir != DIR_NONE), "edge step without direction")
    `TTE_ASSERT(a_step_range, i_clk, i_rst_n, r_edge_step <= 3'd4, "edge step out of range")
    // The button line follows the held flag.
    `TTE_ASSERT(a_btn_line, i_clk, i_rst_n, r_lines[LINE_BTN] == !r_held, "button line disagrees with held flag")

endmodule

// File: tb/target_tracking_encoder_emulator_core_tb.sv
// Self-checking testbench for the light bar encoder emulator: streams ticks and targets, checks the pins.
module target_tracking_encoder_emulator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tte_pkg::*;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_BEAT = 200;

    typedef struct {
        logic       cmd;
        logic       power;
        logic [7:0] bright;
        logic [8:0] mireds;
    } bar_cmd_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bar_cmd_t cmd_q[$];
    t_pins    pins_due_q[$];
    bar_cmd_t on_bus;
    int       fails = 0;
    int       beats_seen;
    int       burst_left;
    int       gap_left;
    int       hold_left;
    bit       hold_done;
    int       rx_mode;
    int       rx_cycle;
    int       idle_cycles;

    // Predictor state.
    logic [STEP_INT_W-1:0]     cfg_step;
    logic [EDGE_INT_W-1:0]     cfg_edge;
    logic [PRESS_TIME_W-1:0]   cfg_press;
    logic                      cal_on;
    logic [5:0]                cal_cnt;
    logic [1:0]                adj_ph;
    logic                      btn_down;
    logic                      pwr_now, pwr_goal;
    logic [2:0]                lvl_now, lvl_goal;
    logic [3:0]                tint_now, tint_goal;
    logic [2:0]                edge_pos;
    logic [1:0]                edge_way;
    logic [2:0]                pins;
    logic [TTE_TIMER_BITS-1:0] t_step, t_press, t_edge;

    target_tracking_encoder_emulator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void bar_reset();
        cfg_step  = STEP_INT_RST;
        cfg_edge  = EDGE_INT_RST;
        cfg_press = PRESS_TIME_RST;
        cal_on    = 1'b1;
        cal_cnt   = '0;
        adj_ph    = PH_POWER;
        btn_down  = 1'b0;
        pwr_now   = 1'b0;
        pwr_goal  = 1'b0;
        lvl_now   = '0;
        lvl_goal  = '0;
        tint_now  = '0;
        tint_goal = '0;
        edge_pos  = '0;
        edge_way  = DIR_NONE;
        pins      = '1;
        t_step    = '0;
        t_press   = '0;
        t_edge    = '0;
    endfunction

    function automatic logic [TTE_TIMER_BITS-1:0] sat_inc(input logic [TTE_TIMER_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [2:0] level_of(input logic [7:0] b);
        return 3'((int'(b) * LevelMax + 127) / LevelDiv);
    endfunction

    function automatic logic [3:0] tint_of(input logic [8:0] m);
        int mc;
        mc = int'(m);
        if (mc < TempLo) mc = TempLo;
        if (mc > TempHi) mc = TempHi;
        return 4'(TintMax - (mc - TempLo + TempSpan / 2) / TempSpan);
    endfunction

    function automatic void begin_step(input logic up);
        edge_pos = 3'd1;
        edge_way = up ? DIR_UP : DIR_DOWN;
    endfunction

    function automatic void hold_button();
        btn_down       = 1'b1;
        pins[LINE_BTN] = 1'b0;
        t_press        = '0;
    endfunction

    function automatic void free_button();
        btn_down       = 1'b0;
        pins[LINE_BTN] = 1'b1;
    endfunction

    function automatic logic press_elapsed();
        return 32'(t_press) > 32'(cfg_press);
    endfunction

    function automatic void calibrate();
        if (cal_cnt < 6'(TTE_CAL_STEPS)) begin
            begin_step(1'b0);
            cal_cnt = cal_cnt + 6'd1;
        end else if (cal_cnt < 6'(2 * TTE_CAL_STEPS)) begin
            if (!btn_down) begin
                hold_button();
            end else if (press_elapsed()) begin
                begin_step(1'b0);
                cal_cnt = cal_cnt + 6'd1;
            end
        end else if (btn_down) begin
            if (press_elapsed()) begin
                free_button();
                t_press = '0;
            end
        end else if (press_elapsed()) begin
            cal_on = 1'b0;
        end
    endfunction

    function automatic void adjust();
        case (adj_ph)
            PH_POWER: begin
                if (pwr_now == pwr_goal) begin
                    adj_ph = PH_LEVEL;
                end else if (!btn_down) begin
                    hold_button();
                end else if (press_elapsed()) begin
                    free_button();
                    pwr_now = pwr_goal;
                end
            end
            PH_LEVEL: begin
                if (!pwr_now || lvl_now == lvl_goal) begin
                    adj_ph = PH_TINT;
                end else if (lvl_now > lvl_goal) begin
                    begin_step(1'b0);
                    lvl_now = lvl_now - 3'd1;
                end else begin
                    begin_step(1'b1);
                    lvl_now = lvl_now + 3'd1;
                end
            end
            PH_TINT: begin
                if (!pwr_now) begin
                    adj_ph = PH_IDLE;
                end else if (tint_now == tint_goal) begin
                    if (!btn_down) begin
                        if (press_elapsed()) adj_ph = PH_IDLE;
                    end else begin
                        free_button();
                        t_press = '0;
                    end
                end else if (!btn_down) begin
                    hold_button();
                end else if (press_elapsed()) begin
                    if (tint_now > tint_goal) begin
                        begin_step(1'b0);
                        tint_now = tint_now - 4'd1;
                    end else begin
                        begin_step(1'b1);
                        tint_now = tint_now + 4'd1;
                    end
                end
            end
            default: begin
                adj_ph = PH_POWER;
            end
        endcase
    endfunction

    function automatic void edge_tick();
        int lead;
        int lag;
        if (32'(t_edge) < 32'(cfg_edge)) return;
        if (edge_way == DIR_NONE || edge_pos == 3'd0) return;
        lead = (edge_way == DIR_UP) ? LINE_A : LINE_B;
        lag  = (edge_way == DIR_UP) ? LINE_B : LINE_A;
        case (edge_pos)
            3'd1: pins[lead] = 1'b0;
            3'd2: pins[lag]  = 1'b0;
            3'd3: pins[lead] = 1'b1;
            3'd4: pins[lag]  = 1'b1;
            default: ;
        endcase
        edge_pos = edge_pos + 3'd1;
        if (edge_pos >= 3'd5) begin
            edge_pos = '0;
            edge_way = DIR_NONE;
        end
        t_edge = '0;
    endfunction

    function automatic t_pins bar_pins_after(input bar_cmd_t c);
        t_pins r;
        if (c.cmd == CMD_LOAD) begin
            pwr_goal  = c.power;
            lvl_goal  = level_of(c.bright);
            tint_goal = tint_of(c.mireds);
        end else begin
            t_step  = sat_inc(t_step);
            t_press = sat_inc(t_press);
            t_edge  = sat_inc(t_edge);
            if (32'(t_step) >= 32'(cfg_step)) begin
                if (cal_on) calibrate();
                else adjust();
                t_step = '0;
            end
            edge_tick();
        end
        r.button      = pins[LINE_BTN];
        r.phase_a     = pins[LINE_A];
        r.phase_b     = pins[LINE_B];
        r.calibrating = cal_on;
        return r;
    endfunction

    function automatic bar_cmd_t mk_cmd(input logic cmd, input logic pwr,
                                        input logic [7:0] b, input logic [8:0] m);
        bar_cmd_t c;
        c.cmd    = cmd;
        c.power  = pwr;
        c.bright = b;
        c.mireds = m;
        return c;
    endfunction

    function automatic bar_cmd_t random_cmd(input int load_pct);
        logic [8:0] m;
        if ($urandom_range(0, 7) == 0) m = 9'($urandom_range(0, 511));
        else m = 9'($urandom_range(TempLo, TempHi));
        return mk_cmd(($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_TICK,
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), m);
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : driver
        bar_cmd_t c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 1;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pins_due_q.push_back(bar_pins_after(on_bus));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    c = cmd_q.pop_front();
                    on_bus        <= c;
                    s_axis_tdata  <= {6'd0, c.mireds, c.bright, c.power};
                    s_axis_tuser  <= c.cmd;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
            rx_mode       <= 0;
            rx_cycle      <= 0;
        end else if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_cycle == 0) rx_mode <= $urandom_range(0, 2);
            rx_cycle <= (rx_cycle + 1) % 48;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        t_pins got;
        t_pins want;
        if (!i_rst_n) begin
            beats_seen <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got = t_pins'(m_axis_tdata[3:0]);
            beats_seen <= beats_seen + 1;
            if (pins_due_q.size() == 0) begin
                $error("result beat arrived with no expectation pending");
                fails++;
            end else begin
                want = pins_due_q.pop_front();
                check_field("button_line", want.button, got.button);
                check_field("phase_a_line", want.phase_a, got.phase_a);
                check_field("phase_b_line", want.phase_b, got.phase_b);
                check_field("calibrating", want.calibrating, got.calibrating);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic settle();
        while (cmd_q.size() != 0 || s_axis_tvalid || pins_due_q.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STEP_INT:   cfg_step  = val[STEP_INT_W-1:0];
            REG_EDGE_INT:   cfg_edge  = val[EDGE_INT_W-1:0];
            REG_PRESS_TIME: cfg_press = val[PRESS_TIME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input int s, input int e, input int p, input int n, input int load_pct);
        settle();
        reg_write(REG_STEP_INT, 32'(s));
        reg_write(REG_EDGE_INT, 32'(e));
        reg_write(REG_PRESS_TIME, 32'(p));
        @(negedge i_clk);
        repeat (n) cmd_q.push_back(random_cmd(load_pct));
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_TICK;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        bar_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: field extremes, brightness and temperature boundaries, clamping.
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b1, 8'd255, 9'd511));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b1, 8'd255, 9'd152));
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b0, 8'd0, 9'd304));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b1, 8'd18, 9'd0));
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b1, 8'd19, 9'd151));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b0, 8'd127, 9'd305));
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b1, 8'd170, 9'd341));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b1, 8'd128, 9'd511));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b1, 8'd36, 9'd161));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b0, 8'd37, 9'd162));
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b0, 8'd85, 9'd170));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b1, 8'd255, 9'd256));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b0, 8'd73, 9'd170));
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(CMD_LOAD, 1'b1, 8'd218, 9'd228));
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(CMD_TICK, 1'b0, 8'd0, 9'd0));

        run_phase(1, 1, 1, 160, 6);
        run_phase(0, 0, 0, 100, 8);
        run_phase(1, 3, 2, 100, 6);
        run_phase(1, 1000, 1, 40, 10);
        run_phase(1000, 1, 5000, 40, 10);
        run_phase(1023, 1023, 8191, 30, 10);
        repeat (2) begin
            run_phase($urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 8), 100, 6);
        end

        while (cmd_q.size() != 0 || s_axis_tvalid || pins_due_q.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fails == 0 && pins_due_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
